// File: rtl/ctb_pkg.sv
// Shared types and constants for the climb-rate tone beeper.
package ctb_pkg;

   localparam int SMOOTH_FRAC_BITS_DEF = 4;
   localparam int TIME_BITS_DEF        = 32;

   localparam int VARIO_W    = 12;
   localparam int NOW_W      = 32;
   localparam int HZ_W       = 13;
   localparam int PWM_W      = 16;
   localparam int LEN_W      = 14;
   localparam int QUIET_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DEN_W      = 16;

   localparam int PWM_CLOCK_NUM   = 256 * 1100;
   localparam int PULSE_NUM       = 10000;
   localparam int PULSE_BASE_MS   = 200;
   localparam int SINK_LEN_MS     = 300;
   localparam int SINK_RESTART_MS = 50;
   localparam int SINK_FLOOR_CMS  = -600;
   localparam int SINK_BASE_HZ    = 150;
   localparam int CLAMP_MAX_CMS   = 900;
   localparam int QUIET_BAND_CMS  = 20;
   localparam int SMOOTH_OFFSET   = 900;
   localparam int SMOOTH_KEEP     = 10;
   localparam int SMOOTH_DEN      = 11;
   // floor(x * 13108 / 65536) equals floor(x / 5) for every x the sink path produces.
   localparam int DIV5_RECIP      = 13108;
   localparam int DIV5_SHIFT      = 16;
   // floor(y * 14564 / 131072) equals floor(y / 9) for every 14-bit y.
   localparam int DIV9_RECIP      = 14564;
   localparam int DIV9_SHIFT      = 17;
   localparam int THR_RESET_CMS   = -300;

   localparam logic [1:0] VOL_MID  = 2'd2;
   localparam logic [1:0] VOL_HIGH = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLUME   = 3'd0,
      CSR_MUTE_EN  = 3'd1,
      CSR_QUIET_MS = 3'd2,
      CSR_SINK_EN  = 3'd3,
      CSR_SINK_THR = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PRE,
      OP_SINK,
      OP_DIV_PER,
      OP_PER_LATCH,
      OP_TONE,
      OP_SMOOTH_NUM,
      OP_SMOOTH,
      OP_DIV_PULSE,
      OP_BEEP,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic tone_req;
      logic v_pos;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/ctb_div.sv
// Restoring serial divider, one quotient bit per cycle.
module ctb_div
   import ctb_pkg::*;
#(
   parameter int NUM_W = 20,
   parameter int DW    = DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DW-1:0]    den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W);

   logic [DW:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DW-1:0]      den_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff, done_ff;
   logic [DW:0]        shifted;
   logic [DW+1:0]      trial;
   logic               fits;
   logic               last;

   always_comb begin
      shifted = {rem_ff[DW-1:0], quo_ff[NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      fits    = ~trial[DW+1];
      rem_in  = fits ? trial[DW:0] : shifted;
      quo_in  = {quo_ff[NUM_W-2:0], fits};
      last    = (cnt_ff == CNT_W'(NUM_W - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// File: rtl/ctb_dp.sv
// Datapath: configuration, beeper state, operand selection and result register.
module ctb_dp
   import ctb_pkg::*;
#(
   parameter int SMOOTH_FRAC_BITS = SMOOTH_FRAC_BITS_DEF,
   parameter int TIME_BITS        = TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   input  logic signed [VARIO_W-1:0]    req_vario_cms,
   input  logic [NOW_W-1:0]             req_now_ms,
   input  logic                         csr_valid,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_tone_on,
   output logic [HZ_W-1:0]              rsp_tone_hz,
   output logic [PWM_W-1:0]             rsp_timer_period,
   output logic [PWM_W-1:0]             rsp_timer_compare
);

   localparam int F  = SMOOTH_FRAC_BITS;
   localparam int T  = TIME_BITS;
   localparam int SW = HZ_W + F;
   localparam int NW = (16 + F > 19) ? 16 + F : 19;
   // Division by 11 through a reciprocal: exact for every numerator below 2^NW.
   localparam int SK = NW + 4;
   localparam int MW = NW + 1;
   localparam logic [MW-1:0] SMOOTH_RECIP =
      MW'(((64'd1 << SK) + 64'(SMOOTH_DEN - 1)) / 64'(SMOOTH_DEN));

   // configuration
   logic [1:0]                vol_ff;
   logic                      mute_en_ff, sink_en_ff;
   logic [QUIET_W-1:0]        quiet_ms_ff;
   logic signed [VARIO_W-1:0] thr_ff;

   // item and beeper state
   logic signed [VARIO_W-1:0] v_ff;
   logic [T-1:0]              now_ff;
   logic [SW-1:0]             smooth_ff, smooth_in;
   logic                      beep_active_ff, beep_active_in;
   logic [T-1:0]              beep_start_ff, beep_start_in;
   logic                      playing_ff, playing_in;
   logic [T-1:0]              tone_start_ff, tone_start_in;
   logic [LEN_W-1:0]          tone_len_ff, tone_len_in;
   logic [PWM_W-1:0]          period_ff, period_in;
   logic [PWM_W-1:0]          compare_ff, compare_in;
   logic                      muted_ff, muted_in;
   logic [T-1:0]              quiet_since_ff, quiet_since_in;
   logic [HZ_W-1:0]           last_hz_ff, last_hz_in;
   logic [HZ_W-1:0]           tone_freq_ff, tone_freq_in;
   logic [LEN_W-1:0]          pend_len_ff, pend_len_in;
   logic [PWM_W-1:0]          pend_period_ff, pend_period_in;
   logic [NW-1:0]             smooth_num_ff;
   logic                      tone_req_ff, tone_req_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_on_ff;
   logic [HZ_W-1:0]           rsp_hz_ff;
   logic [PWM_W-1:0]          rsp_per_ff, rsp_cmp_ff;

   // derived values
   logic signed [VARIO_W-1:0] vc;
   logic signed [VARIO_W:0]   vc13, mag13, vf13;
   logic [VARIO_W-1:0]        mag;
   logic [10:0]               sink_x;
   logic [24:0]               sink_prod;
   logic [HZ_W-1:0]           sink_freq;
   logic                      sink_cond, quiet;
   logic [T-1:0]              el_tone, el_quiet, el_beep;
   logic [LEN_W-1:0]          pulse, pulse_limit;
   logic [NW-1:0]             smooth_num;
   logic [NW+MW-1:0]          smooth_prod;
   logic [27:0]               cmp36_prod;
   logic [PWM_W-1:0]          cmp_val;
   logic                      div_start, div_done;
   logic [NW-1:0]             div_num, div_q;
   logic [DEN_W-1:0]          div_den;

   assign vc   = (v_ff > VARIO_W'(CLAMP_MAX_CMS)) ? VARIO_W'(CLAMP_MAX_CMS) : v_ff;
   assign vc13 = {vc[VARIO_W-1], vc};
   assign mag13 = (vc13 < 0) ? -vc13 : vc13;
   assign mag  = mag13[VARIO_W-1:0];
   assign vf13 = (vc13 < (VARIO_W+1)'(SINK_FLOOR_CMS)) ? (VARIO_W+1)'(SINK_FLOOR_CMS) : vc13;
   assign sink_x    = 11'(vf13 - (VARIO_W+1)'(SINK_FLOOR_CMS));
   assign sink_prod = 25'(sink_x) * 25'(DIV5_RECIP);
   assign sink_freq = HZ_W'(sink_prod[24:DIV5_SHIFT]) + HZ_W'(SINK_BASE_HZ);
   assign sink_cond = sink_en_ff && (vc <= thr_ff);
   assign quiet     = mute_en_ff && (v_ff > -VARIO_W'(QUIET_BAND_CMS))
                      && (v_ff < VARIO_W'(QUIET_BAND_CMS));
   assign el_tone   = now_ff - tone_start_ff;
   assign el_quiet  = now_ff - quiet_since_ff;
   assign el_beep   = now_ff - beep_start_ff;
   assign pulse       = div_q[LEN_W-1:0] + LEN_W'(PULSE_BASE_MS);
   assign pulse_limit = pulse + (pulse >> 1);

   assign smooth_num  = NW'(smooth_ff) * NW'(SMOOTH_KEEP)
                        + (NW'({mag, 1'b0} + (VARIO_W+1)'(SMOOTH_OFFSET)) << F);
   assign smooth_prod = (NW+MW)'(smooth_num_ff) * (NW+MW)'(SMOOTH_RECIP);

   // Dividing by 36 is a shift by two followed by a reciprocal divide by 9.
   assign cmp36_prod = 28'(pend_period_ff[PWM_W-1:2]) * 28'(DIV9_RECIP);

   always_comb begin
      case (vol_ff)
         VOL_MID:  cmp_val = PWM_W'(cmp36_prod[27:DIV9_SHIFT]);
         VOL_HIGH: cmp_val = {1'b0, pend_period_ff[PWM_W-1:1]};
         default:  cmp_val = {8'd0, pend_period_ff[PWM_W-1:8]};
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (cmd.op)
         OP_DIV_PER: begin
            div_start = 1'b1;
            div_num   = NW'(PWM_CLOCK_NUM);
            div_den   = DEN_W'(tone_freq_ff);
         end
         OP_DIV_PULSE: begin
            div_start = 1'b1;
            div_num   = NW'(PULSE_NUM);
            div_den   = DEN_W'(vc[VARIO_W-2:0]);
         end
         default: ;
      endcase
   end

   ctb_div #(.NUM_W(NW), .DW(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      smooth_in      = smooth_ff;
      beep_active_in = beep_active_ff;
      beep_start_in  = beep_start_ff;
      playing_in     = playing_ff;
      tone_start_in  = tone_start_ff;
      tone_len_in    = tone_len_ff;
      period_in      = period_ff;
      compare_in     = compare_ff;
      muted_in       = muted_ff;
      quiet_since_in = quiet_since_ff;
      last_hz_in     = last_hz_ff;
      tone_freq_in   = tone_freq_ff;
      pend_len_in    = pend_len_ff;
      pend_period_in = pend_period_ff;
      tone_req_in    = tone_req_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         OP_PRE: begin
            if (playing_ff && (el_tone > T'(tone_len_ff)))
               playing_in = 1'b0;
            if (quiet) begin
               if (el_quiet > T'(quiet_ms_ff))
                  muted_in = 1'b1;
            end else begin
               quiet_since_in = now_ff;
               muted_in       = 1'b0;
            end
         end
         OP_SINK: begin
            tone_req_in  = 1'b0;
            tone_freq_in = sink_freq;
            pend_len_in  = LEN_W'(SINK_LEN_MS);
            if (sink_cond) begin
               if (beep_active_ff) begin
                  if (el_beep >= T'(SINK_RESTART_MS)) begin
                     beep_active_in = 1'b0;
                     tone_req_in    = 1'b1;
                  end
               end else begin
                  tone_req_in    = 1'b1;
                  beep_active_in = 1'b1;
                  beep_start_in  = now_ff;
               end
            end
         end
         OP_PER_LATCH: begin
            // A zero frequency makes the divider return all ones, which saturates too.
            pend_period_in = (div_q > NW'({PWM_W{1'b1}})) ? {PWM_W{1'b1}} : div_q[PWM_W-1:0];
         end
         OP_TONE: begin
            period_in     = pend_period_ff;
            compare_in    = cmp_val;
            last_hz_in    = tone_freq_ff;
            tone_start_in = now_ff;
            tone_len_in   = pend_len_ff;
            playing_in    = 1'b1;
         end
         OP_SMOOTH: smooth_in = smooth_prod[SK+SW-1:SK];
         OP_BEEP: begin
            tone_req_in = 1'b0;
            if (!muted_ff) begin
               if (beep_active_ff) begin
                  if (el_beep > T'(pulse_limit)) begin
                     beep_active_in = 1'b0;
                     playing_in     = 1'b0;
                  end
               end else begin
                  tone_freq_in   = smooth_ff[SW-1:F];
                  pend_len_in    = pulse;
                  tone_req_in    = 1'b1;
                  beep_active_in = 1'b1;
                  beep_start_in  = now_ff;
               end
            end
         end
         OP_PUBLISH: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff         <= '0;
         mute_en_ff     <= 1'b1;
         quiet_ms_ff    <= '0;
         sink_en_ff     <= 1'b1;
         thr_ff         <= VARIO_W'(THR_RESET_CMS);
         smooth_ff      <= '0;
         beep_active_ff <= 1'b0;
         beep_start_ff  <= '0;
         playing_ff     <= 1'b0;
         tone_start_ff  <= '0;
         tone_len_ff    <= '0;
         period_ff      <= '0;
         compare_ff     <= '0;
         muted_ff       <= 1'b0;
         quiet_since_ff <= '0;
         last_hz_ff     <= '0;
         tone_req_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         smooth_ff      <= smooth_in;
         beep_active_ff <= beep_active_in;
         beep_start_ff  <= beep_start_in;
         playing_ff     <= playing_in;
         tone_start_ff  <= tone_start_in;
         tone_len_ff    <= tone_len_in;
         period_ff      <= period_in;
         compare_ff     <= compare_in;
         muted_ff       <= muted_in;
         quiet_since_ff <= quiet_since_in;
         last_hz_ff     <= last_hz_in;
         tone_req_ff    <= tone_req_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_VOLUME:   vol_ff      <= csr_wdata[1:0];
               CSR_MUTE_EN:  mute_en_ff  <= csr_wdata[0];
               CSR_QUIET_MS: quiet_ms_ff <= csr_wdata[QUIET_W-1:0];
               CSR_SINK_EN:  sink_en_ff  <= csr_wdata[0];
               CSR_SINK_THR: thr_ff      <= csr_wdata[VARIO_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      tone_freq_ff   <= tone_freq_in;
      pend_len_ff    <= pend_len_in;
      pend_period_ff <= pend_period_in;
      if (cmd.op == OP_LOAD) begin
         v_ff   <= req_vario_cms;
         now_ff <= T'(req_now_ms);
      end
      if (cmd.op == OP_SMOOTH_NUM) begin
         smooth_num_ff <= smooth_num;
      end
      if (cmd.op == OP_PUBLISH) begin
         rsp_on_ff  <= playing_ff;
         rsp_hz_ff  <= last_hz_ff;
         rsp_per_ff <= period_ff;
         rsp_cmp_ff <= compare_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.tone_req = tone_req_ff;
   assign status.v_pos    = (vc > 0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tone_on       = rsp_on_ff;
   assign rsp_tone_hz       = rsp_hz_ff;
   assign rsp_timer_period  = rsp_per_ff;
   assign rsp_timer_compare = rsp_cmp_ff;

endmodule

// File: rtl/ctb_ctrl.sv
// Controller: sequences the steps of one sample through the datapath.
module ctb_ctrl
   import ctb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_PRE, S_SINK, S_SINK_CHK, S_PER, S_PER_W, S_TONE,
      S_SMOOTH, S_SMOOTH_SET, S_PULSE, S_PULSE_W, S_BEEP_CHK, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ret_beep_ff, ret_beep_in;

   always_comb begin
      state_in    = state_ff;
      ret_beep_in = ret_beep_ff;
      cmd.op      = OP_NONE;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.op   = OP_LOAD;
            state_in = S_PRE;
         end
         S_PRE: begin
            cmd.op   = OP_PRE;
            state_in = S_SINK;
         end
         S_SINK: begin
            cmd.op   = OP_SINK;
            state_in = S_SINK_CHK;
         end
         S_SINK_CHK: begin
            ret_beep_in = 1'b0;
            state_in    = status.tone_req ? S_PER : S_SMOOTH;
         end
         S_PER: begin
            cmd.op   = OP_DIV_PER;
            state_in = S_PER_W;
         end
         S_PER_W: if (status.div_done) begin
            cmd.op   = OP_PER_LATCH;
            state_in = S_TONE;
         end
         S_TONE: begin
            cmd.op   = OP_TONE;
            state_in = ret_beep_ff ? S_DONE : S_SMOOTH;
         end
         S_SMOOTH: begin
            cmd.op   = OP_SMOOTH_NUM;
            state_in = S_SMOOTH_SET;
         end
         S_SMOOTH_SET: begin
            cmd.op   = OP_SMOOTH;
            state_in = status.v_pos ? S_PULSE : S_DONE;
         end
         S_PULSE: begin
            cmd.op   = OP_DIV_PULSE;
            state_in = S_PULSE_W;
         end
         S_PULSE_W: if (status.div_done) begin
            cmd.op   = OP_BEEP;
            state_in = S_BEEP_CHK;
         end
         S_BEEP_CHK: begin
            ret_beep_in = 1'b1;
            state_in    = status.tone_req ? S_PER : S_DONE;
         end
         S_DONE: if (status.out_free) begin
            cmd.op   = OP_PUBLISH;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ret_beep_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_beep_ff <= ret_beep_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// File: rtl/climb_rate_tone_beeper.sv
// Top level of the climb-rate tone beeper: controller plus datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_vario_cms, req_now_ms
//   rsp      out        rsp_valid/rsp_ready  rsp_tone_on, rsp_tone_hz,
//                                            rsp_timer_period, rsp_timer_compare
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One sample at a time, with N = max(19, 16 + SMOOTH_FRAC_BITS) bits per serial division.
// A sample runs one division for the pulse length when the rate is positive and one
// more for the timer period of each tone started, also when both the sink tone and a
// climb beep start; the serial divider thus sets how long a sample takes.
// The result register lets the next sample be taken while a result waits.
// Reset is synchronous; payload registers carry no reset.
// csr_ready is always high.
module climb_rate_tone_beeper
   import ctb_pkg::*;
#(
   parameter int SMOOTH_FRAC_BITS = SMOOTH_FRAC_BITS_DEF,
   parameter int TIME_BITS        = TIME_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VARIO_W-1:0] req_vario_cms,
   input  logic [NOW_W-1:0]          req_now_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_tone_on,
   output logic [HZ_W-1:0]           rsp_tone_hz,
   output logic [PWM_W-1:0]          rsp_timer_period,
   output logic [PWM_W-1:0]          rsp_timer_compare,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   ctb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ctb_dp #(
      .SMOOTH_FRAC_BITS (SMOOTH_FRAC_BITS),
      .TIME_BITS        (TIME_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_vario_cms     (req_vario_cms),
      .req_now_ms        (req_now_ms),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tone_on       (rsp_tone_on),
      .rsp_tone_hz       (rsp_tone_hz),
      .rsp_timer_period  (rsp_timer_period),
      .rsp_timer_compare (rsp_timer_compare)
   );

endmodule

// File: rtl/ctb_checker.sv
// Port-level checks for the climb-rate tone beeper, bound to the top level.
module ctb_checker
   import ctb_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [HZ_W-1:0]   rsp_tone_hz,
   input logic [PWM_W-1:0]  rsp_timer_period,
   input logic [PWM_W-1:0]  rsp_timer_compare
);

   // A sample transfer makes the block busy: req_ready falls once the sample is taken.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after a sample transfer");

   // The compare value is the period divided by at least two.
   a_compare_below_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_timer_compare < rsp_timer_period || rsp_timer_period == '0)
      else $error("timer_compare not below timer_period");

   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result shown right after reset");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tone_hz)
         && $stable(rsp_timer_period))
      else $error("stalled result changed");

endmodule

bind climb_rate_tone_beeper ctb_checker u_ctb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_tone_hz       (rsp_tone_hz),
   .rsp_timer_period  (rsp_timer_period),
   .rsp_timer_compare (rsp_timer_compare)
);
